### sv/tefill_pkg.sv
// Shared types and constants for the triangle edge fill test.
// Holds the word structs, register indexes and the arithmetic widths.
`timescale 1ns / 1ps

package tefill_pkg;

	// screen geometry defaults
	localparam int ScreenWidthDef  = 800;
	localparam int ScreenHeightDef = 480;

	// field widths
	localparam int PixXW   = 10;
	localparam int PixYW   = 9;
	localparam int AddrW   = 19;
	localparam int ColorW  = 32;
	localparam int CoordW  = 12;
	localparam int DimW    = 12;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	// arithmetic widths of the edge functions
	localparam int CoefW  = CoordW + 1;
	localparam int ProdW  = 2 * CoordW;
	localparam int ConstW = ProdW + 1;
	localparam int EdgeW  = ConstW + 2;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [CoefW-1:0]  coef_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [ConstW-1:0] const_t;
	typedef logic signed [EdgeW-1:0]  edge_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_VERTEX_A_X = 3'd0,
		REG_VERTEX_A_Y = 3'd1,
		REG_VERTEX_B_X = 3'd2,
		REG_VERTEX_B_Y = 3'd3,
		REG_VERTEX_C_X = 3'd4,
		REG_VERTEX_C_Y = 3'd5,
		REG_FILL_COLOR = 3'd6
	} reg_idx_t;

	typedef struct packed {
		coord_t              vertex_a_x;
		coord_t              vertex_a_y;
		coord_t              vertex_b_x;
		coord_t              vertex_b_y;
		coord_t              vertex_c_x;
		coord_t              vertex_c_y;
		logic [ColorW-1:0]   fill_color;
	} cfg_t;

	typedef struct packed {
		logic [PixXW-1:0] pixel_x;
		logic [PixYW-1:0] pixel_y;
	} pixel_in_t;

	typedef struct packed {
		logic              write_enable;
		logic [AddrW-1:0]  pixel_address;
		logic [ColorW-1:0] pixel_color;
	} pixel_out_t;

	// load enables of the pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

### sv/tefill_cfg.sv
// Configuration register file of the triangle edge fill test.
// Depends on tefill_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module tefill_cfg import tefill_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t regs_q;

	// decode the index and load the addressed register; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_VERTEX_A_X: regs_q.vertex_a_x <= coord_t'(cfg_data[CoordW-1:0]);
				REG_VERTEX_A_Y: regs_q.vertex_a_y <= coord_t'(cfg_data[CoordW-1:0]);
				REG_VERTEX_B_X: regs_q.vertex_b_x <= coord_t'(cfg_data[CoordW-1:0]);
				REG_VERTEX_B_Y: regs_q.vertex_b_y <= coord_t'(cfg_data[CoordW-1:0]);
				REG_VERTEX_C_X: regs_q.vertex_c_x <= coord_t'(cfg_data[CoordW-1:0]);
				REG_VERTEX_C_Y: regs_q.vertex_c_y <= coord_t'(cfg_data[CoordW-1:0]);
				REG_FILL_COLOR: regs_q.fill_color <= cfg_data[ColorW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

### sv/tefill_edge.sv
// One edge function unit: evaluates E = A*x + B*y + C at the pixel and at
// the opposite vertex over three stages. Depends on tefill_pkg.
`timescale 1ns / 1ps

module tefill_edge import tefill_pkg::*; (
	input  logic             clk,
	input  stage_en_t        en,
	input  coord_t           p_x,
	input  coord_t           p_y,
	input  coord_t           q_x,
	input  coord_t           q_y,
	input  coord_t           o_x,
	input  coord_t           o_y,
	input  logic [PixXW-1:0] pix_x_s1,
	input  logic [PixYW-1:0] pix_y_s1,
	output logic             ok
);

	coef_t  a_s1, b_s1;
	prod_t  qp_s1, pq_s1;
	const_t c_s2;
	prod_t  ax_s2, by_s2;
	const_t ao_s2, bo_s2;
	edge_t  e_s3, r_s3;

	// form the line coefficients and the two cross products
	always_ff @(posedge clk) begin
		if (en.s1) begin
			a_s1  <= coef_t'(q_y) - coef_t'(p_y);
			b_s1  <= coef_t'(p_x) - coef_t'(q_x);
			qp_s1 <= prod_t'(q_x) * prod_t'(p_y);
			pq_s1 <= prod_t'(p_x) * prod_t'(q_y);
		end
	end

	// finish C and scale A and B by the pixel and by the opposite vertex
	always_ff @(posedge clk) begin
		if (en.s2) begin
			c_s2  <= const_t'(qp_s1) - const_t'(pq_s1);
			ax_s2 <= prod_t'(a_s1) * prod_t'($signed({1'b0, pix_x_s1}));
			by_s2 <= prod_t'(b_s1) * prod_t'($signed({1'b0, pix_y_s1}));
			ao_s2 <= const_t'(a_s1) * const_t'(o_x);
			bo_s2 <= const_t'(b_s1) * const_t'(o_y);
		end
	end

	// sum the terms at the pixel and at the opposite vertex
	always_ff @(posedge clk) begin
		if (en.s3) begin
			e_s3 <= edge_t'(ax_s2) + edge_t'(by_s2) + edge_t'(c_s2);
			r_s3 <= edge_t'(ao_s2) + edge_t'(bo_s2) + edge_t'(c_s2);
		end
	end

	// both values nonzero and of the same sign
	assign ok = (e_s3 != '0) && (r_s3 != '0) && (e_s3[EdgeW-1] == r_s3[EdgeW-1]);

endmodule

### sv/triangle_edge_fill_test.sv
// Tests one pixel a cycle against a configured triangle: a four stage pipeline
// (coefficients and cross products, multiplies, sums, sign test) accepts a new
// pixel word in every cycle while out_ready is high or a stage is empty, and
// carries it through stages s1 to s3 into the output register s4;
// while the output register is stalled, the stages behind it keep taking words
// into empty slots. Pixels on an edge, off screen or against a collinear
// triangle get write_enable low; the address and colour are always given.
// Write the vertex registers only while no word is in flight.
// Depends on tefill_pkg, tefill_cfg and tefill_edge.
`timescale 1ns / 1ps

module triangle_edge_fill_test import tefill_pkg::*; #(
	parameter int SCREEN_WIDTH  = ScreenWidthDef,
	parameter int SCREEN_HEIGHT = ScreenHeightDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  pixel_in_t           in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pixel_out_t          out_data
);

	localparam logic [DimW-1:0]  WidthDim  = DimW'(SCREEN_WIDTH);
	localparam logic [DimW-1:0]  HeightDim = DimW'(SCREEN_HEIGHT);
	localparam logic [AddrW-1:0] WidthAddr = AddrW'(SCREEN_WIDTH);

	cfg_t      cfg;
	stage_en_t en;
	logic      v_s1, v_s2, v_s3, v_s4;
	logic [PixXW-1:0] x_s1, x_s2;
	logic [PixYW-1:0] y_s1;
	logic      onscr_s1, onscr_s2, onscr_s3;
	logic [AddrW-1:0] addr_s2, addr_s3;
	logic [2:0] edge_ok;
	pixel_out_t out_s4;

	tefill_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// advance a stage when it is empty or the stage after it advances
	always_comb begin
		en.s4 = !v_s4 || out_ready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_ready = en.s1;

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	// edge one a to b, edge two c to b, edge three a to c
	tefill_edge u_edge_ab (
		.clk (clk), .en (en),
		.p_x (cfg.vertex_a_x), .p_y (cfg.vertex_a_y),
		.q_x (cfg.vertex_b_x), .q_y (cfg.vertex_b_y),
		.o_x (cfg.vertex_c_x), .o_y (cfg.vertex_c_y),
		.pix_x_s1 (x_s1), .pix_y_s1 (y_s1), .ok (edge_ok[0])
	);

	tefill_edge u_edge_cb (
		.clk (clk), .en (en),
		.p_x (cfg.vertex_c_x), .p_y (cfg.vertex_c_y),
		.q_x (cfg.vertex_b_x), .q_y (cfg.vertex_b_y),
		.o_x (cfg.vertex_a_x), .o_y (cfg.vertex_a_y),
		.pix_x_s1 (x_s1), .pix_y_s1 (y_s1), .ok (edge_ok[1])
	);

	tefill_edge u_edge_ac (
		.clk (clk), .en (en),
		.p_x (cfg.vertex_a_x), .p_y (cfg.vertex_a_y),
		.q_x (cfg.vertex_c_x), .q_y (cfg.vertex_c_y),
		.o_x (cfg.vertex_b_x), .o_y (cfg.vertex_b_y),
		.pix_x_s1 (x_s1), .pix_y_s1 (y_s1), .ok (edge_ok[2])
	);

	// capture the pixel and check it against the screen bounds
	always_ff @(posedge clk) begin
		if (en.s1) begin
			x_s1     <= in_data.pixel_x;
			y_s1     <= in_data.pixel_y;
			onscr_s1 <= (DimW'(in_data.pixel_x) < WidthDim) &&
			            (DimW'(in_data.pixel_y) < HeightDim);
		end
	end

	// scale the row by the screen width, wrapping at the address width
	always_ff @(posedge clk) begin
		if (en.s2) begin
			addr_s2  <= AddrW'(y_s1) * WidthAddr;
			x_s2     <= x_s1;
			onscr_s2 <= onscr_s1;
		end
	end

	// add the column
	always_ff @(posedge clk) begin
		if (en.s3) begin
			addr_s3  <= addr_s2 + AddrW'(x_s2);
			onscr_s3 <= onscr_s2;
		end
	end

	// output register: combine the edge tests
	always_ff @(posedge clk) begin
		if (en.s4) begin
			out_s4.write_enable  <= onscr_s3 && (&edge_ok);
			out_s4.pixel_address <= addr_s3;
			out_s4.pixel_color   <= cfg.fill_color;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = out_s4;

endmodule

### sv/tefill_check.sv
// Port checker for the triangle edge fill test, bound to the top level.
// Depends on tefill_pkg for the word structs.
`timescale 1ns / 1ps

module tefill_check import tefill_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input pixel_in_t  in_data,
	input logic       out_valid,
	input logic       out_ready,
	input pixel_out_t out_data
);

	logic [2:0] count_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// track words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc && !out_acc) begin
			count_q <= count_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			count_q <= count_q - 3'd1;
		end
	end

	// never more words in flight than there are stages
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("more words in flight than pipeline stages");

	// no result without a word accepted for it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_q != 3'd0)
		else $error("result word with no accepted pixel");

	// an empty output register means the pipeline can take a word
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result word changed");

endmodule

bind triangle_edge_fill_test tefill_check u_tefill_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
